/* design/derivative_peak_detector_core_assert.svh */
// -----------------------------------------------------------------------------
// Assertion macros for the derivative peak detector
// Concurrent checks that compile to nothing when ASSERT_OFF is defined.
// -----------------------------------------------------------------------------
`ifndef DERIVATIVE_PEAK_DETECTOR_CORE_ASSERT_SVH
`define DERIVATIVE_PEAK_DETECTOR_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define DPD_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("derivative peak detector: check failed");
`define DPD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("derivative peak detector: check failed");
`define DPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("derivative peak detector: check failed");
`else
`define DPD_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define DPD_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define DPD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* design/dpd_pkg.sv */
// -----------------------------------------------------------------------------
// Derivative peak detector package
// Field widths, register indices and shared types.
// -----------------------------------------------------------------------------
package dpd_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int INDEX_W    = 12;
    localparam int COUNT_W    = 4;
    localparam int SW_W       = 4;
    localparam int MINSEP_W   = 12;
    localparam int MAXPK_W    = 4;
    localparam int FLOOR_W    = 16;
    localparam int STD_W      = 15;
    localparam int THR_W      = 18;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int WIN_DEPTH     = 32;
    localparam int WIN_AW        = 5;
    localparam int WIN_CAP_LIMIT = (WIN_DEPTH - 2) / 2;

    localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_WINDOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SEPARATION = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PEAKS      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NOISE_FLOOR    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NOISE_STD      = 3'd4;

    // One slope decision handed to the decision stage; seed marks the
    // index-zero step, which only records the opening slope sign.
    typedef struct packed {
        logic valid;
        logic seed;
    } dpd_step_t;

endpackage

/* design/dpd_ram.sv */
// -----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// -----------------------------------------------------------------------------
module dpd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* design/dpd_decide.sv */
// -----------------------------------------------------------------------------
// Derivative peak detector decision stage
// Compares the slope signs, checks the threshold and merges the candidate
// into the peak list with a parallel compare against all stored peaks.
// -----------------------------------------------------------------------------
`include "derivative_peak_detector_core_assert.svh"

module dpd_decide #(
    parameter int MAX_PEAKS = 8,
    parameter int IDX_W     = 13,
    localparam int FOUND_W  = $clog2(MAX_PEAKS + 1),
    localparam int LIM_W    = (FOUND_W > dpd_pkg::MAXPK_W) ? FOUND_W : dpd_pkg::MAXPK_W
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                clear,
    input  dpd_pkg::dpd_step_t                  step,
    input  logic [IDX_W-1:0]                    idx,
    input  logic signed [dpd_pkg::SAMPLE_W-1:0] hi_sample,
    input  logic signed [dpd_pkg::SAMPLE_W-1:0] lo_sample,
    input  logic signed [dpd_pkg::SAMPLE_W-1:0] mid_sample,
    input  logic [dpd_pkg::MINSEP_W-1:0]        min_separation,
    input  logic [LIM_W-1:0]                    limit,
    input  logic signed [dpd_pkg::THR_W-1:0]    threshold,
    output logic [IDX_W-1:0]                    pos [MAX_PEAKS],
    output logic signed [dpd_pkg::SAMPLE_W-1:0] lvl [MAX_PEAKS],
    output logic [FOUND_W-1:0]                  found
);

    import dpd_pkg::*;

    localparam int DW = (IDX_W > MINSEP_W) ? IDX_W : MINSEP_W;

    logic [IDX_W-1:0]           pos_reg [MAX_PEAKS];
    logic signed [SAMPLE_W-1:0] lvl_reg [MAX_PEAKS];
    logic [FOUND_W-1:0]         found_reg;
    logic                       prev_reg;

    logic                       cur;
    logic                       above;
    logic                       room;
    logic                       cand;
    logic [MAX_PEAKS-1:0]       near;
    logic [MAX_PEAKS-1:0]       first;
    logic [MAX_PEAKS-1:0]       replace;
    logic signed [SAMPLE_W-1:0] sel_lvl;
    logic                       bigger;
    logic                       append;

    assign cur   = hi_sample > lo_sample;
    assign above = $signed({{(THR_W - SAMPLE_W){mid_sample[SAMPLE_W-1]}}, mid_sample})
                   > threshold;
    assign room  = LIM_W'(found_reg) < limit;
    assign cand  = step.valid && !step.seed && room && prev_reg && !cur && above;

    always_comb
    begin : p_match
        logic taken;
        logic [DW-1:0] gap;
        taken   = 1'b0;
        sel_lvl = '0;
        for (int j = 0; j < MAX_PEAKS; j++)
        begin
            gap      = DW'(idx) - DW'(pos_reg[j]);
            near[j]  = (found_reg > FOUND_W'(j)) && (gap < DW'(min_separation));
            first[j] = near[j] && !taken;
            taken    = taken | near[j];
            if (first[j])
            begin
                sel_lvl = lvl_reg[j];
            end
        end
    end

    assign bigger  = mid_sample > sel_lvl;
    assign replace = (cand && bigger) ? first : '0;
    assign append  = cand && !(|near);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= '0;
            prev_reg  <= 1'b0;
        end
        else if (clear)
        begin
            found_reg <= '0;
            prev_reg  <= 1'b0;
        end
        else
        begin
            if (step.valid)
            begin
                prev_reg <= cur;
            end
            if (append)
            begin
                found_reg <= found_reg + FOUND_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < MAX_PEAKS; j++)
        begin
            if (replace[j] || (append && (found_reg == FOUND_W'(j))))
            begin
                pos_reg[j] <= idx;
                lvl_reg[j] <= mid_sample;
            end
        end
    end

    assign pos   = pos_reg;
    assign lvl   = lvl_reg;
    assign found = found_reg;

    `DPD_ASSERT_ALWAYS(a_found_bound, clk, rst_n, found_reg <= FOUND_W'(MAX_PEAKS))
    `DPD_ASSERT_ALWAYS(a_single_write, clk, rst_n, $onehot0(replace) && !(append && (|replace)))
    `DPD_ASSERT_NEXT(a_found_grows, clk, rst_n, !clear, found_reg >= $past(found_reg))

endmodule

/* design/dpd_emit.sv */
// -----------------------------------------------------------------------------
// Derivative peak detector result buffer
// Holds a finished peak list and presents it one peak per request.
// -----------------------------------------------------------------------------
module dpd_emit #(
    parameter int MAX_PEAKS = 8,
    parameter int IDX_W     = 13,
    localparam int FOUND_W  = $clog2(MAX_PEAKS + 1)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                load,
    input  logic [IDX_W-1:0]                    pos [MAX_PEAKS],
    input  logic signed [dpd_pkg::SAMPLE_W-1:0] lvl [MAX_PEAKS],
    input  logic [FOUND_W-1:0]                  found,
    output logic                                busy,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [dpd_pkg::INDEX_W-1:0]         peak_index,
    output logic signed [dpd_pkg::SAMPLE_W-1:0] peak_amplitude,
    output logic [dpd_pkg::COUNT_W-1:0]         peak_count,
    output logic                                end_of_list
);

    import dpd_pkg::*;

    logic [INDEX_W-1:0]         slot_pos_reg [MAX_PEAKS];
    logic signed [SAMPLE_W-1:0] slot_lvl_reg [MAX_PEAKS];
    logic [FOUND_W-1:0]         remaining_reg;
    logic [FOUND_W-1:0]         total_reg;
    logic                       busy_reg;
    logic                       pop;

    assign pop = busy_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            remaining_reg <= '0;
            total_reg     <= '0;
        end
        else if (load)
        begin
            busy_reg  <= 1'b1;
            total_reg <= found;
            if (found == '0)
            begin
                remaining_reg <= FOUND_W'(1);
            end
            else
            begin
                remaining_reg <= found;
            end
        end
        else if (pop)
        begin
            remaining_reg <= remaining_reg - FOUND_W'(1);
            if (remaining_reg == FOUND_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int j = 0; j < MAX_PEAKS; j++)
            begin
                slot_pos_reg[j] <= INDEX_W'(pos[j]);
                slot_lvl_reg[j] <= lvl[j];
            end
            if (found == '0)
            begin
                slot_pos_reg[0] <= '0;
                slot_lvl_reg[0] <= '0;
            end
        end
        else if (pop)
        begin
            for (int j = 0; j < MAX_PEAKS - 1; j++)
            begin
                slot_pos_reg[j] <= slot_pos_reg[j + 1];
                slot_lvl_reg[j] <= slot_lvl_reg[j + 1];
            end
        end
    end

    assign busy           = busy_reg;
    assign out_valid      = busy_reg;
    assign peak_index     = slot_pos_reg[0];
    assign peak_amplitude = slot_lvl_reg[0];
    assign peak_count     = COUNT_W'(total_reg);
    assign end_of_list    = (remaining_reg == FOUND_W'(1));

endmodule

/* design/derivative_peak_detector_core.sv */
// -----------------------------------------------------------------------------
// Derivative peak detector core
// One sample a cycle, bar one stall per record for the opening slope, until last;
// input then waits until the list is handed over. The window is at most 15, and
// the first result is valid once the output is free. Results go one per request.
// Reset restores register defaults.
`include "derivative_peak_detector_core_assert.svh"

module derivative_peak_detector_core #(
    parameter int MAX_PEAKS   = 8,
    parameter int MAX_SAMPLES = 4096,
    parameter int MAX_WINDOW  = 15
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [dpd_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [dpd_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [dpd_pkg::SAMPLE_W-1:0]   sample,
    input  logic                                  last,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [dpd_pkg::INDEX_W-1:0]           peak_index,
    output logic signed [dpd_pkg::SAMPLE_W-1:0]   peak_amplitude,
    output logic [dpd_pkg::COUNT_W-1:0]           peak_count,
    output logic                                  end_of_list
);

    import dpd_pkg::*;

    localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
    localparam int EXT_W   = CNT_W + 1;
    localparam int FOUND_W = $clog2(MAX_PEAKS + 1);
    localparam int LIM_W   = (FOUND_W > MAXPK_W) ? FOUND_W : MAXPK_W;
    localparam int WCAP    = (MAX_WINDOW < WIN_CAP_LIMIT) ? MAX_WINDOW : WIN_CAP_LIMIT;

    logic [SW_W-1:0]          smooth_window_reg;
    logic [MINSEP_W-1:0]      min_separation_reg;
    logic [MAXPK_W-1:0]       peak_limit_reg;
    logic [FLOOR_W-1:0]       noise_floor_reg;
    logic [STD_W-1:0]         noise_std_reg;
    logic signed [THR_W-1:0]  thr_reg;
    logic [THR_W-1:0]         thr_next;

    logic [CNT_W-1:0]         cnt_reg;
    logic [CNT_W-1:0]         ptr_reg;
    logic                     end_reg;
    dpd_step_t                step_reg;
    logic [CNT_W-1:0]         idx_reg;

    logic [SW_W-1:0]          w_eff;
    logic [LIM_W-1:0]         limit;
    logic [EXT_W-1:0]         cnt_x;
    logic [EXT_W-1:0]         ptr_x;
    logic [EXT_W-1:0]         w_x;
    logic [EXT_W-1:0]         q_x;
    logic [EXT_W-1:0]         qn_x;
    logic [EXT_W-1:0]         hi_x;
    logic [EXT_W-1:0]         lo_x;
    logic [CNT_W-1:0]         top;
    logic                     pending_now;
    logic                     pending_more;
    logic                     issue;
    logic                     in_accept;
    logic                     handover;
    logic                     emit_busy;
    logic                     win_we;
    logic [WIN_AW-1:0]        hi_addr;
    logic [WIN_AW-1:0]        lo_addr;
    logic [WIN_AW-1:0]        mid_addr;
    logic [SAMPLE_W-1:0]      hi_data;
    logic [SAMPLE_W-1:0]      lo_data;
    logic [SAMPLE_W-1:0]      mid_data;

    logic [CNT_W-1:0]         peak_pos [MAX_PEAKS];
    logic signed [SAMPLE_W-1:0] peak_lvl [MAX_PEAKS];
    logic [FOUND_W-1:0]       found;

    assign w_eff = (smooth_window_reg > SW_W'(WCAP)) ? SW_W'(WCAP) : smooth_window_reg;
    assign limit = (LIM_W'(peak_limit_reg) > LIM_W'(MAX_PEAKS)) ? LIM_W'(MAX_PEAKS)
                                                                : LIM_W'(peak_limit_reg);

    assign thr_next = {{(THR_W - FLOOR_W){noise_floor_reg[FLOOR_W-1]}}, noise_floor_reg}
                    + {3'b000, noise_std_reg}
                    + {2'b00, noise_std_reg, 1'b0};

    // Index zero is a seed step that takes the same condition as index one.
    assign cnt_x = {1'b0, cnt_reg};
    assign ptr_x = {1'b0, ptr_reg};
    assign w_x   = EXT_W'(w_eff);
    assign q_x   = (ptr_reg == '0) ? EXT_W'(1) : ptr_x;
    assign qn_x  = ptr_x + EXT_W'(1);

    assign pending_now  = (q_x + EXT_W'(1) < cnt_x) && (end_reg || (q_x + w_x < cnt_x));
    assign pending_more = (qn_x + EXT_W'(1) < cnt_x) && (end_reg || (qn_x + w_x < cnt_x));

    assign issue     = pending_now;
    assign in_ready  = !end_reg && (!pending_now || !pending_more);
    assign in_accept = in_valid && in_ready;
    assign handover  = end_reg && !pending_now && !step_reg.valid && !emit_busy;
    assign win_we    = in_accept && (cnt_reg < CNT_W'(MAX_SAMPLES));

    assign top      = cnt_reg - CNT_W'(1);
    assign hi_x     = ptr_x + w_x;
    assign lo_x     = (ptr_x > w_x) ? (ptr_x - w_x) : '0;
    assign hi_addr  = (hi_x < cnt_x) ? hi_x[WIN_AW-1:0] : top[WIN_AW-1:0];
    assign lo_addr  = lo_x[WIN_AW-1:0];
    assign mid_addr = ptr_reg[WIN_AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smooth_window_reg  <= SW_W'(2);
            min_separation_reg <= MINSEP_W'(4);
            peak_limit_reg     <= MAXPK_W'(8);
            noise_floor_reg    <= '0;
            noise_std_reg      <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_SMOOTH_WINDOW:  smooth_window_reg  <= cfg_data[SW_W-1:0];
                REG_MIN_SEPARATION: min_separation_reg <= cfg_data[MINSEP_W-1:0];
                REG_MAX_PEAKS:      peak_limit_reg     <= cfg_data[MAXPK_W-1:0];
                REG_NOISE_FLOOR:    noise_floor_reg    <= cfg_data[FLOOR_W-1:0];
                REG_NOISE_STD:      noise_std_reg      <= cfg_data[STD_W-1:0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            ptr_reg  <= '0;
            end_reg  <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            step_reg.valid <= issue;
            step_reg.seed  <= (ptr_reg == '0);
            if (handover)
            begin
                cnt_reg <= '0;
                ptr_reg <= '0;
                end_reg <= 1'b0;
            end
            else
            begin
                if (issue)
                begin
                    ptr_reg <= ptr_reg + CNT_W'(1);
                end
                if (win_we)
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
                if (in_accept && last)
                begin
                    end_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= ptr_reg;
        thr_reg <= thr_next;
    end

    dpd_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WIN_DEPTH)
    ) u_ram_hi (
        .clk   (clk),
        .we    (win_we),
        .waddr (cnt_reg[WIN_AW-1:0]),
        .wdata (sample),
        .raddr (hi_addr),
        .rdata (hi_data)
    );

    dpd_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WIN_DEPTH)
    ) u_ram_lo (
        .clk   (clk),
        .we    (win_we),
        .waddr (cnt_reg[WIN_AW-1:0]),
        .wdata (sample),
        .raddr (lo_addr),
        .rdata (lo_data)
    );

    dpd_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WIN_DEPTH)
    ) u_ram_mid (
        .clk   (clk),
        .we    (win_we),
        .waddr (cnt_reg[WIN_AW-1:0]),
        .wdata (sample),
        .raddr (mid_addr),
        .rdata (mid_data)
    );

    dpd_decide #(
        .MAX_PEAKS (MAX_PEAKS),
        .IDX_W     (CNT_W)
    ) u_decide (
        .clk            (clk),
        .rst_n          (rst_n),
        .clear          (handover),
        .step           (step_reg),
        .idx            (idx_reg),
        .hi_sample      ($signed(hi_data)),
        .lo_sample      ($signed(lo_data)),
        .mid_sample     ($signed(mid_data)),
        .min_separation (min_separation_reg),
        .limit          (limit),
        .threshold      (thr_reg),
        .pos            (peak_pos),
        .lvl            (peak_lvl),
        .found          (found)
    );

    dpd_emit #(
        .MAX_PEAKS (MAX_PEAKS),
        .IDX_W     (CNT_W)
    ) u_emit (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (handover),
        .pos            (peak_pos),
        .lvl            (peak_lvl),
        .found          (found),
        .busy           (emit_busy),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .peak_index     (peak_index),
        .peak_amplitude (peak_amplitude),
        .peak_count     (peak_count),
        .end_of_list    (end_of_list)
    );

    `DPD_ASSERT_ALWAYS(a_ptr_within_count, clk, rst_n, ptr_reg <= cnt_reg)
    `DPD_ASSERT_NEXT(a_last_closes_input, clk, rst_n, in_accept && last, !in_ready)
    `DPD_ASSERT_NEXT(a_handover_loads, clk, rst_n, handover, out_valid && (cnt_reg == '0))

endmodule

/* bench/peak_list_checker.sv */
// -----------------------------------------------------------------------------
// Peak list checker for the derivative peak detector
// Watches the register port and both request channels, keeps its own model of
// the slope-sign peak search, and compares every peak result with the oldest
// predicted one. It reports mismatches and the number of results outstanding.
// -----------------------------------------------------------------------------
module peak_list_checker (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [dpd_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [dpd_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                  in_valid,
    input  logic                                  in_ready,
    input  logic signed [dpd_pkg::SAMPLE_W-1:0]   sample,
    input  logic                                  last,
    input  logic                                  out_valid,
    input  logic                                  out_ready,
    input  logic [dpd_pkg::INDEX_W-1:0]           peak_index,
    input  logic signed [dpd_pkg::SAMPLE_W-1:0]   peak_amplitude,
    input  logic [dpd_pkg::COUNT_W-1:0]           peak_count,
    input  logic                                  end_of_list,
    output int                                    mismatches,
    output int                                    outstanding,
    output int                                    results_checked
);

    import dpd_pkg::*;

    localparam int PEAK_SLOTS   = 8;
    localparam int RECORD_LIMIT = 4096;

    typedef struct packed {
        logic [INDEX_W-1:0]         idx;
        logic signed [SAMPLE_W-1:0] amp;
        logic [COUNT_W-1:0]         cnt;
        logic                       eol;
    } peak_rec_t;

    logic [SW_W-1:0]            cf_window;
    logic [MINSEP_W-1:0]        cf_sep;
    logic [MAXPK_W-1:0]         cf_maxpk;
    logic signed [FLOOR_W-1:0]  cf_floor;
    logic [STD_W-1:0]           cf_std;

    logic signed [SAMPLE_W-1:0] win_mem [WIN_DEPTH];
    int unsigned                n_taken;
    bit                         prev_up;
    int unsigned                pk_pos [PEAK_SLOTS];
    int                         pk_amp [PEAK_SLOTS];
    int unsigned                n_found;
    int unsigned                next_pos;

    peak_rec_t                  expected_peaks [$];

    function automatic bit slope_up(int unsigned i, int unsigned top, int unsigned w);
        int unsigned lo;
        int unsigned hi;
        lo = (i > w) ? i - w : 0;
        hi = (i + w > top) ? top : i + w;
        return int'(win_mem[hi % WIN_DEPTH]) > int'(win_mem[lo % WIN_DEPTH]);
    endfunction

    function automatic void judge_index(int unsigned i, int unsigned top, int unsigned w);
        bit          now_up;
        bit          was_up;
        bit          placed;
        int unsigned limit;
        int unsigned j;
        int          thr;
        int          v;
        now_up = slope_up(i, top, w);
        was_up = (i == 1) ? slope_up(0, top, w) : prev_up;
        limit  = (cf_maxpk > PEAK_SLOTS) ? PEAK_SLOTS : cf_maxpk;
        thr    = int'(cf_floor) + 3 * int'(cf_std);
        v      = int'(win_mem[i % WIN_DEPTH]);
        prev_up = now_up;
        if (n_found >= limit || !was_up || now_up || v <= thr)
            return;
        placed = 1'b0;
        for (j = 0; j < n_found && !placed; j++)
        begin
            if (i - pk_pos[j] < cf_sep)
            begin
                if (v > pk_amp[j])
                begin
                    pk_pos[j] = i;
                    pk_amp[j] = v;
                end
                placed = 1'b1;
            end
        end
        if (!placed && n_found < PEAK_SLOTS)
        begin
            pk_pos[n_found] = i;
            pk_amp[n_found] = v;
            n_found++;
        end
    endfunction

    function automatic void clear_record();
        n_taken  = 0;
        prev_up  = 1'b0;
        n_found  = 0;
        next_pos = 1;
    endfunction

    function automatic void take_sample(logic signed [SAMPLE_W-1:0] s, logic lst);
        int unsigned w;
        int unsigned top;
        int unsigned k;
        peak_rec_t   r;
        w = cf_window;
        if (n_taken < RECORD_LIMIT)
        begin
            win_mem[n_taken % WIN_DEPTH] = s;
            n_taken++;
        end
        top = n_taken - 1;
        if (lst)
        begin
            while (next_pos + 1 < n_taken)
            begin
                judge_index(next_pos, top, w);
                next_pos++;
            end
            if (n_found == 0)
            begin
                r = '0;
                r.eol = 1'b1;
                expected_peaks.push_back(r);
                outstanding++;
            end
            for (k = 0; k < n_found; k++)
            begin
                r.idx = INDEX_W'(pk_pos[k]);
                r.amp = SAMPLE_W'(pk_amp[k]);
                r.cnt = COUNT_W'(n_found);
                r.eol = (k + 1 == n_found);
                expected_peaks.push_back(r);
                outstanding++;
            end
            clear_record();
        end
        else
        begin
            while (next_pos + w <= top && next_pos + 1 < n_taken)
            begin
                judge_index(next_pos, top, w);
                next_pos++;
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        peak_rec_t want;
        if (!rst_n)
        begin
            cf_window = 4'd2;
            cf_sep    = 12'd4;
            cf_maxpk  = 4'd8;
            cf_floor  = '0;
            cf_std    = '0;
            for (int i = 0; i < WIN_DEPTH; i++)
                win_mem[i] = '0;
            clear_record();
            expected_peaks.delete();
            mismatches      = 0;
            outstanding     = 0;
            results_checked = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_peaks.size() == 0)
                begin
                    $display("%0t unexpected peak result: index %0d amplitude %0d count %0d end %0b",
                             $time, peak_index, peak_amplitude, peak_count, end_of_list);
                    mismatches++;
                end
                else
                begin
                    want = expected_peaks.pop_front();
                    outstanding--;
                    results_checked++;
                    if (peak_index !== want.idx || peak_amplitude !== want.amp ||
                        peak_count !== want.cnt || end_of_list !== want.eol)
                    begin
                        $display("%0t peak result mismatch: expected index %0d amplitude %0d %s",
                                 $time, want.idx, want.amp,
                                 $sformatf("count %0d end %0b", want.cnt, want.eol));
                        $display("%0t   actual index %0d amplitude %0d count %0d end %0b",
                                 $time, peak_index, peak_amplitude, peak_count, end_of_list);
                        mismatches++;
                    end
                end
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_SMOOTH_WINDOW:  cf_window = cfg_data[SW_W-1:0];
                    REG_MIN_SEPARATION: cf_sep    = cfg_data[MINSEP_W-1:0];
                    REG_MAX_PEAKS:      cf_maxpk  = cfg_data[MAXPK_W-1:0];
                    REG_NOISE_FLOOR:    cf_floor  = cfg_data[FLOOR_W-1:0];
                    REG_NOISE_STD:      cf_std    = cfg_data[STD_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                take_sample(sample, last);
        end
    end

endmodule

/* bench/derivative_peak_detector_core_tb.sv */
// -----------------------------------------------------------------------------
// Testbench for the derivative peak detector core
// Sends directed and random waveform records through a series of register
// settings and idling patterns; the peak list checker predicts and compares
// every result.
// -----------------------------------------------------------------------------
module derivative_peak_detector_core_tb;
    import dpd_pkg::*;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idling_t;

    localparam int SETTLE_CYCLES   = 48;
    localparam int PHASE_SAMPLES   = 7;
    localparam int RANDOM_PHASES   = 12;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [CFG_DATA_W-1:0]      cfg_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic signed [SAMPLE_W-1:0] sample = '0;
    logic                       last = 1'b0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic [INDEX_W-1:0]         peak_index;
    logic signed [SAMPLE_W-1:0] peak_amplitude;
    logic [COUNT_W-1:0]         peak_count;
    logic                       end_of_list;

    int mismatches;
    int outstanding;
    int results_checked;
    int idle_pct = 0;
    int stall_pct = 0;
    int records_sent = 0;
    int samples_sent = 0;
    int settings_used = 0;

    int directed_samples [19] = '{32767, -32768, 32767, 0, 100, 0,
                                  -32768, 32767, -32768, 32767, -32768, 32767, -32768,
                                  0, 5, 5, 0, 10, 3};
    int directed_lengths [5] = '{1, 2, 3, 7, 6};

    derivative_peak_detector_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .sample         (sample),
        .last           (last),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .peak_index     (peak_index),
        .peak_amplitude (peak_amplitude),
        .peak_count     (peak_count),
        .end_of_list    (end_of_list)
    );

    peak_list_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .sample          (sample),
        .last            (last),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .peak_index      (peak_index),
        .peak_amplitude  (peak_amplitude),
        .peak_count      (peak_count),
        .end_of_list     (end_of_list),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .results_checked (results_checked)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= stall_pct);

    task automatic set_idling(input idling_t mode);
        case (mode)
            IDLE_NONE:     begin idle_pct = 0;  stall_pct = 0;  end
            IDLE_SENDER:   begin idle_pct = 49; stall_pct = 0;  end
            IDLE_RECEIVER: begin idle_pct = 0;  stall_pct = 49; end
            IDLE_BOTH:     begin idle_pct = 23; stall_pct = 23; end
            default:       begin idle_pct = 0;  stall_pct = 0;  end
        endcase
    endtask

    task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] word);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= word;
        @(posedge clk);
    endtask

    task automatic apply_settings(input logic [SW_W-1:0] w, input logic [MINSEP_W-1:0] sep,
                                  input logic [MAXPK_W-1:0] mp,
                                  input logic signed [FLOOR_W-1:0] fl,
                                  input logic [STD_W-1:0] sd);
        cfg_put(REG_SMOOTH_WINDOW, CFG_DATA_W'(w));
        cfg_put(REG_MIN_SEPARATION, CFG_DATA_W'(sep));
        cfg_put(REG_MAX_PEAKS, CFG_DATA_W'(mp));
        cfg_put(REG_NOISE_FLOOR, CFG_DATA_W'(fl));
        cfg_put(REG_NOISE_STD, CFG_DATA_W'(sd));
        cfg_write <= 1'b0;
        settings_used++;
    endtask

    // Called just after a rising edge; returns at the edge that took the request.
    task automatic push_sample(input logic signed [SAMPLE_W-1:0] s, input logic lst);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= s;
        last     <= lst;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        samples_sent++;
    endtask

    task automatic send_record(input int len, input bit noisy);
        int lvl;
        int step;
        lvl  = int'($urandom_range(8000)) - 4000;
        step = 1 << $urandom_range(14, 6);
        for (int k = 0; k < len; k++)
        begin
            if (noisy)
                lvl = int'($urandom_range(65535)) - 32768;
            else
                lvl = lvl + int'($urandom_range(2 * step)) - step;
            if (lvl > 32767)
                lvl = 32767;
            if (lvl < -32768)
                lvl = -32768;
            push_sample(SAMPLE_W'(lvl), k == len - 1);
        end
        records_sent++;
    endtask

    task automatic wait_quiet();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic choose_settings(input int phase);
        case (phase)
            0: apply_settings(4'd2, 12'd4, 4'd8, 16'sd0, 15'd0);
            1: apply_settings(4'd1, 12'd0, 4'd15, -16'sd32768, 15'd0);
            2: apply_settings(4'd15, 12'd4095, 4'd1, -16'sd500, 15'd100);
            3: apply_settings(4'd0, 12'd3, 4'd8, 16'sd0, 15'd0);
            4: apply_settings(4'd3, 12'd2, 4'd0, -16'sd1000, 15'd10);
            5: apply_settings(4'd4, 12'd1, 4'd8, 16'sd32767, 15'd0);
            6: apply_settings(4'd6, 12'd5, 4'd8, -16'sd32768, 15'd32767);
            default: apply_settings(SW_W'($urandom_range(15, 1)),
                                    MINSEP_W'(($urandom_range(3) == 0) ? $urandom_range(4095)
                                                                       : $urandom_range(12)),
                                    MAXPK_W'($urandom_range(8, 1)),
                                    FLOOR_W'(int'($urandom_range(6000)) - 3000),
                                    STD_W'($urandom_range(800)));
        endcase
    endtask

    initial
    begin : stimulus
        int pos;
        int len;
        int r;
        int phase_count;
        pos = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Short records, full-scale samples, merging within the separation
        // and an equal-level plateau.
        set_idling(IDLE_NONE);
        apply_settings(4'd1, 12'd4, 4'd8, 16'sd0, 15'd0);
        for (int rec = 0; rec < 5; rec++)
        begin
            for (int k = 0; k < directed_lengths[rec]; k++)
            begin
                push_sample(SAMPLE_W'(directed_samples[pos]), k == directed_lengths[rec] - 1);
                pos++;
            end
            records_sent++;
        end
        wait_quiet();

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            set_idling(idling_t'(phase % 4));
            choose_settings(phase);
            phase_count = 0;
            while (phase_count < PHASE_SAMPLES)
            begin
                r = $urandom_range(99);
                if (r < 8)
                    len = $urandom_range(2, 1);
                else if (r < 85)
                    len = $urandom_range(16, 3);
                else
                    len = $urandom_range(40, 25);
                send_record(len, $urandom_range(3) == 0);
                phase_count += len;
            end
            wait_quiet();
        end

        $display("Covered %0d records and %0d samples under %0d register settings;",
                 records_sent, samples_sent, settings_used);
        $display("%0d peak results checked, %0d mismatches.", results_checked, mismatches);
        if (mismatches == 0 && outstanding == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin : watchdog
        #3000000;
        $display("FAILURE");
        $finish;
    end

endmodule
